// ----- hw/rtl/msso_pkg.sv -----
`default_nettype none
package msso_pkg;
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_PROT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_PROTO_A = 2'd0,
    CFG_PROTO_B = 2'd1,
    CFG_PROTO_C = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_RECV   = 2'd1,
    OP_STATUS = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_READ = 2'd2,
    BK_DONE = 2'd3
  } bk_state_e;
endpackage
`default_nettype wire

// ----- hw/rtl/msso_front.sv -----
`default_nettype none
module msso_front import msso_pkg::*; #(
  parameter int NUM_BOXES    = 16,
  parameter int PAYLOAD_BITS = 64,
  parameter int BOX_W        = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [7:0]              cfg_data_i,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire logic                    req_type_i,
  input  wire logic [15:0]             own_id_i,
  input  wire logic [3:0]              own_box_i,
  input  wire logic [15:0]             dest_id_i,
  input  wire logic [3:0]              dest_box_i,
  input  wire logic                    dest_exists_i,
  input  wire logic [7:0]              protocol_i,
  input  wire logic [63:0]             payload_i,
  output logic                         q_valid_o,
  input  wire logic                    q_ready_i,
  output op_e                          q_op_o,
  output status_e                      q_status_o,
  output logic [BOX_W-1:0]             q_box_o,
  output logic [15:0]                  q_sender_o,
  output logic [7:0]                   q_proto_o,
  output logic [PAYLOAD_BITS-1:0]      q_payload_o
);
  logic [7:0] pa_q, pb_q, pc_q;
  logic       full_q;
  op_e        op_q, op_d;
  status_e    st_q, st_d;
  logic [BOX_W-1:0] box_q, box_d;
  logic [15:0] snd_q;
  logic [7:0]  pr_q;
  logic [PAYLOAD_BITS-1:0] pl_q;
  logic        take;
  logic [3:0]  sel_box;
  logic        box_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q <= 8'd0; pb_q <= 8'd1; pc_q <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROTO_A: pa_q <= cfg_data_i;
        CFG_PROTO_B: pb_q <= cfg_data_i;
        CFG_PROTO_C: pc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ready_o = !full_q || q_ready_i;
  assign take    = valid_i && ready_o;
  assign sel_box = req_type_i ? own_box_i : dest_box_i;
  assign box_ok  = {28'd0, sel_box} < NUM_BOXES;

  // classify: receive on a bad box and failed sends need no slot work
  always_comb begin
    st_d  = ST_OK;
    op_d  = OP_STATUS;
    box_d = sel_box[BOX_W-1:0];
    if (req_type_i) begin
      op_d = box_ok ? OP_RECV : OP_STATUS;
    end else if (dest_id_i == 16'd0 || !dest_exists_i || !box_ok) begin
      st_d = ST_FAIL;
    end else if (protocol_i != pa_q && protocol_i != pb_q && protocol_i != pc_q) begin
      st_d = ST_PROT;
    end else begin
      op_d = OP_SEND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (take) begin
      full_q <= 1'b1;
    end else if (q_ready_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= op_d;
      st_q  <= st_d;
      box_q <= box_d;
      snd_q <= own_id_i;
      pr_q  <= protocol_i;
      pl_q  <= payload_i[PAYLOAD_BITS-1:0];
    end
  end

  assign q_valid_o   = full_q;
  assign q_op_o      = op_q;
  assign q_status_o  = st_q;
  assign q_box_o     = box_q;
  assign q_sender_o  = snd_q;
  assign q_proto_o   = pr_q;
  assign q_payload_o = pl_q;
endmodule
`default_nettype wire

// ----- hw/rtl/msso_back.sv -----
`default_nettype none
module msso_back import msso_pkg::*; #(
  parameter int NUM_BOXES     = 16,
  parameter int SLOTS_PER_BOX = 8,
  parameter int PAYLOAD_BITS  = 64,
  parameter int BOX_W         = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_valid_i,
  output logic                         q_ready_o,
  input  wire op_e                     q_op_i,
  input  wire status_e                 q_status_i,
  input  wire logic [BOX_W-1:0]        q_box_i,
  input  wire logic [15:0]             q_sender_i,
  input  wire logic [7:0]              q_proto_i,
  input  wire logic [PAYLOAD_BITS-1:0] q_payload_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output logic [1:0]                   status_o,
  output logic                         received_o,
  output logic [15:0]                  msg_sender_o,
  output logic [7:0]                   msg_protocol_o,
  output logic [63:0]                  msg_payload_o,
  output logic [31:0]                  msg_seq_o
);
  localparam int TOTAL = NUM_BOXES * SLOTS_PER_BOX;
  localparam int SW    = (SLOTS_PER_BOX > 1) ? $clog2(SLOTS_PER_BOX) : 1;
  localparam int KW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CW    = $clog2(SLOTS_PER_BOX + 1);
  localparam int RAMW  = 32 + 16 + 8 + PAYLOAD_BITS;

  logic [TOTAL-1:0] busy_q;
  logic [RAMW-1:0]  mem [TOTAL];
  logic [31:0]      seq_ram [TOTAL];
  logic [31:0]      seqrd_q;
  logic [RAMW-1:0]  rd_q;

  bk_state_e st_q, st_d;
  logic [CW-1:0]  cnt_q;
  logic [SW-1:0]  cur_q;
  logic [31:0]    ctr_q;
  logic           found_q, free_found_q;
  logic [SW-1:0]  best_q, free_q;
  logic [31:0]    best_seq_q;
  logic           chk_q;
  logic [SW-1:0]  chk_slot_q;
  logic           out_full_q;
  logic [1:0]     o_st_q;
  logic           o_rcv_q;
  logic [RAMW-1:0] o_msg_q;

  logic [KW-1:0] base;
  logic [KW-1:0] rd_addr;
  logic          scan_done;
  logic          out_free;

  assign base = KW'(q_box_i) * KW'(SLOTS_PER_BOX);
  assign out_free = !out_full_q || ready_i;
  assign scan_done = (cnt_q == CW'(SLOTS_PER_BOX)) && !chk_q;

  // seq read is registered and lags the slot index; check it against the delayed slot index
  always_ff @(posedge clk_i) begin
    seqrd_q <= seq_ram[base + KW'(cur_q)];
    rd_q    <= mem[rd_addr];
  end
  assign rd_addr = base + KW'(best_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (q_valid_i) begin
        if (q_op_i == OP_STATUS) st_d = BK_DONE;
        else st_d = BK_SCAN;
      end
      BK_SCAN: if (scan_done) st_d = (q_op_i == OP_RECV && found_q) ? BK_READ : BK_DONE;
      BK_READ: st_d = BK_DONE;
      BK_DONE: if (out_free) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = (st_q == BK_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      busy_q <= '0;
      ctr_q <= 32'd0;
      cnt_q <= '0;
      cur_q <= '0;
      chk_q <= 1'b0;
      chk_slot_q <= '0;
      found_q <= 1'b0;
      free_found_q <= 1'b0;
      best_q <= '0;
      free_q <= '0;
      best_seq_q <= 32'hFFFF_FFFF;
      out_full_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_DONE && out_free) out_full_q <= 1'b1;
      else if (out_free) out_full_q <= 1'b0;
      unique case (st_q)
        BK_IDLE: begin
          cnt_q <= '0;
          cur_q <= '0;
          chk_q <= 1'b0;
          found_q <= 1'b0;
          free_found_q <= 1'b0;
          best_seq_q <= 32'hFFFF_FFFF;
        end
        BK_SCAN: begin
          if (cnt_q != CW'(SLOTS_PER_BOX)) begin
            chk_q <= 1'b1;
            chk_slot_q <= cur_q;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q != CW'(SLOTS_PER_BOX - 1)) cur_q <= cur_q + 1'b1;
          end else begin
            chk_q <= 1'b0;
          end
          if (chk_q) begin
            if (busy_q[base + KW'(chk_slot_q)]) begin
              if (seqrd_q <= best_seq_q) begin
                found_q <= 1'b1;
                best_q <= chk_slot_q;
                best_seq_q <= seqrd_q;
              end
            end else if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_q <= chk_slot_q;
            end
          end
          if (scan_done && q_op_i == OP_SEND) begin
            ctr_q <= ctr_q + 32'd1;
            if (free_found_q) busy_q[base + KW'(free_q)] <= 1'b1;
          end
          if (scan_done && q_op_i == OP_RECV && found_q)
            busy_q[base + KW'(best_q)] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_SCAN && scan_done && q_op_i == OP_SEND && free_found_q) begin
      mem[base + KW'(free_q)] <= {ctr_q, q_sender_i, q_proto_i, q_payload_i};
      seq_ram[base + KW'(free_q)] <= ctr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_DONE && out_free) begin
      if (q_op_i == OP_SEND) begin
        o_st_q  <= free_found_q ? ST_OK : ST_FAIL;
        o_rcv_q <= 1'b0;
        o_msg_q <= '0;
      end else if (q_op_i == OP_RECV) begin
        o_st_q  <= ST_OK;
        o_rcv_q <= found_q;
        o_msg_q <= found_q ? rd_q : '0;
      end else begin
        o_st_q  <= q_status_i;
        o_rcv_q <= 1'b0;
        o_msg_q <= '0;
      end
    end
  end

  assign valid_o        = out_full_q;
  assign status_o       = o_st_q;
  assign received_o     = o_rcv_q;
  assign msg_seq_o      = o_msg_q[RAMW-1 -: 32];
  assign msg_sender_o   = o_msg_q[RAMW-33 -: 16];
  assign msg_protocol_o = o_msg_q[PAYLOAD_BITS+7 -: 8];
  assign msg_payload_o  = 64'(o_msg_q[PAYLOAD_BITS-1:0]);
endmodule
`default_nettype wire

// ----- hw/rtl/mailbox_slot_store_oldest_first.sv -----
// A send or an empty receive goes from accept through the front register, a scan of the box's
// slots (one slot per cycle through the slot sequence RAM) and the output register; a receive
// that returns a message adds a read stage. Failed sends and bad receive boxes skip the scan.
// The front register holds the beat the back works on and takes the next beat only as the back releases it.
// Reset: all slots free, sequence counter zero, protocol codes 0, 1, 2.
`default_nettype none
module mailbox_slot_store_oldest_first import msso_pkg::*; #(
  parameter int NUM_BOXES     = 16,
  parameter int SLOTS_PER_BOX = 8,
  parameter int PAYLOAD_BITS  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic        req_type_i,
  input  wire logic [15:0] own_id_i,
  input  wire logic [3:0]  own_box_i,
  input  wire logic [15:0] dest_id_i,
  input  wire logic [3:0]  dest_box_i,
  input  wire logic        dest_exists_i,
  input  wire logic [7:0]  protocol_i,
  input  wire logic [63:0] payload_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [1:0]       status_o,
  output logic             received_o,
  output logic [15:0]      msg_sender_o,
  output logic [7:0]       msg_protocol_o,
  output logic [63:0]      msg_payload_o,
  output logic [31:0]      msg_seq_o
);
  localparam int BOX_W = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;

  logic q_valid, q_ready;
  op_e q_op;
  status_e q_status;
  logic [BOX_W-1:0] q_box;
  logic [15:0] q_sender;
  logic [7:0] q_proto;
  logic [PAYLOAD_BITS-1:0] q_payload;

  msso_front #(.NUM_BOXES(NUM_BOXES), .PAYLOAD_BITS(PAYLOAD_BITS), .BOX_W(BOX_W)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_i, .ready_o,
    .req_type_i, .own_id_i, .own_box_i, .dest_id_i, .dest_box_i, .dest_exists_i,
    .protocol_i, .payload_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_op_o(q_op), .q_status_o(q_status),
    .q_box_o(q_box), .q_sender_o(q_sender), .q_proto_o(q_proto), .q_payload_o(q_payload)
  );

  msso_back #(.NUM_BOXES(NUM_BOXES), .SLOTS_PER_BOX(SLOTS_PER_BOX),
              .PAYLOAD_BITS(PAYLOAD_BITS), .BOX_W(BOX_W)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_op_i(q_op), .q_status_i(q_status),
    .q_box_i(q_box), .q_sender_i(q_sender), .q_proto_i(q_proto), .q_payload_i(q_payload),
    .valid_o, .ready_i, .status_o, .received_o, .msg_sender_o, .msg_protocol_o,
    .msg_payload_o, .msg_seq_o
  );
endmodule
`default_nettype wire

// ----- test/msso_checker.sv -----
`timescale 1ns / 100ps
module msso_checker import msso_pkg::*; #(
  parameter int NUM_BOXES     = 16,
  parameter int SLOTS_PER_BOX = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        valid_i,
  input  wire logic        ready_o,
  input  wire logic        req_type_i,
  input  wire logic [15:0] own_id_i,
  input  wire logic [3:0]  own_box_i,
  input  wire logic [15:0] dest_id_i,
  input  wire logic [3:0]  dest_box_i,
  input  wire logic        dest_exists_i,
  input  wire logic [7:0]  protocol_i,
  input  wire logic [63:0] payload_i,
  input  wire logic        valid_o,
  input  wire logic        ready_i,
  input  wire logic [1:0]  status_o,
  input  wire logic        received_o,
  input  wire logic [15:0] msg_sender_o,
  input  wire logic [7:0]  msg_protocol_o,
  input  wire logic [63:0] msg_payload_o,
  input  wire logic [31:0] msg_seq_o,
  output int               fail_count_o,
  output int               pending_o
);
  localparam int NSLOTS = NUM_BOXES * SLOTS_PER_BOX;

  typedef struct packed {
    status_e     status;
    logic        received;
    logic [15:0] sender;
    logic [7:0]  proto;
    logic [63:0] payload;
    logic [31:0] seq;
  } mail_reply_t;

  mail_reply_t reply_q[$];
  logic [7:0]  code_a, code_b, code_c;
  logic        busy[NSLOTS];
  logic [31:0] seq_mem[NSLOTS];
  logic [15:0] sender_mem[NSLOTS];
  logic [7:0]  proto_mem[NSLOTS];
  logic [63:0] payload_mem[NSLOTS];
  logic [31:0] next_seq;

  assign pending_o = reply_q.size();

  function automatic mail_reply_t deliver_mail();
    mail_reply_t r;
    int          base;
    r = '0;
    r.status = ST_OK;
    if (dest_id_i == 16'd0 || !dest_exists_i || int'(dest_box_i) >= NUM_BOXES) begin
      r.status = ST_FAIL;
      return r;
    end
    if (protocol_i != code_a && protocol_i != code_b && protocol_i != code_c) begin
      r.status = ST_PROT;
      return r;
    end
    base = int'(dest_box_i) * SLOTS_PER_BOX;
    r.status = ST_FAIL;
    for (int s = 0; s < SLOTS_PER_BOX; s++) begin
      if (!busy[base + s]) begin
        busy[base + s] = 1'b1;
        seq_mem[base + s] = next_seq;
        sender_mem[base + s] = own_id_i;
        proto_mem[base + s] = protocol_i;
        payload_mem[base + s] = payload_i;
        r.status = ST_OK;
        break;
      end
    end
    // a full box still burns its sequence number
    next_seq = next_seq + 32'd1;
    return r;
  endfunction

  function automatic mail_reply_t collect_oldest();
    mail_reply_t r;
    int          base, pick;
    logic [31:0] oldest;
    r = '0;
    r.status = ST_OK;
    pick = -1;
    oldest = 32'hFFFF_FFFF;
    if (int'(own_box_i) >= NUM_BOXES) return r;
    base = int'(own_box_i) * SLOTS_PER_BOX;
    // later slot wins on a tie
    for (int s = 0; s < SLOTS_PER_BOX; s++) begin
      if (busy[base + s] && seq_mem[base + s] <= oldest) begin
        pick = base + s;
        oldest = seq_mem[base + s];
      end
    end
    if (pick < 0) return r;
    r.received = 1'b1;
    r.sender = sender_mem[pick];
    r.proto = proto_mem[pick];
    r.payload = payload_mem[pick];
    r.seq = seq_mem[pick];
    busy[pick] = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mail_reply_t want;
    if (!rst_ni) begin
      code_a = 8'd0;
      code_b = 8'd1;
      code_c = 8'd2;
      next_seq = '0;
      for (int k = 0; k < NSLOTS; k++) busy[k] = 1'b0;
      reply_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PROTO_A: code_a = cfg_data_i;
          CFG_PROTO_B: code_b = cfg_data_i;
          CFG_PROTO_C: code_c = cfg_data_i;
          default: ;
        endcase
      end
      if (valid_o && ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d", $realtime, status_o);
          fail_count_o++;
        end else begin
          want = reply_q.pop_front();
          if (status_o !== want.status || received_o !== want.received ||
              msg_sender_o !== want.sender || msg_protocol_o !== want.proto ||
              msg_payload_o !== want.payload || msg_seq_o !== want.seq) begin
            $display("%0t: mismatch expected st=%0d rx=%0d snd=%h pr=%h pl=%h sq=%h",
                     $realtime, want.status, want.received, want.sender, want.proto,
                     want.payload, want.seq);
            $display("%0t:          actual   st=%0d rx=%0d snd=%h pr=%h pl=%h sq=%h",
                     $realtime, status_o, received_o, msg_sender_o, msg_protocol_o,
                     msg_payload_o, msg_seq_o);
            fail_count_o++;
          end
        end
      end
      if (valid_i && ready_o) begin
        if (op_e'({1'b0, req_type_i}) == OP_RECV) reply_q.push_back(collect_oldest());
        else reply_q.push_back(deliver_mail());
      end
    end
  end
endmodule

// ----- test/tb_mailbox_slot_store_oldest_first.sv -----
`timescale 1ns / 100ps
module tb_mailbox_slot_store_oldest_first;
  import msso_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic        req_type_i = 1'b0;
  logic [15:0] own_id_i = '0;
  logic [3:0]  own_box_i = '0;
  logic [15:0] dest_id_i = '0;
  logic [3:0]  dest_box_i = '0;
  logic        dest_exists_i = 1'b0;
  logic [7:0]  protocol_i = '0;
  logic [63:0] payload_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        received_o;
  logic [15:0] msg_sender_o;
  logic [7:0]  msg_protocol_o;
  logic [63:0] msg_payload_o;
  logic [31:0] msg_seq_o;
  int          fail_count, pending;

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  logic [7:0]  codes[3] = '{8'd0, 8'd1, 8'd2};

  always #6 clk_i = ~clk_i;

  mailbox_slot_store_oldest_first uut (.*);

  msso_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_i, .ready_o,
    .req_type_i, .own_id_i, .own_box_i, .dest_id_i, .dest_box_i, .dest_exists_i,
    .protocol_i, .payload_i, .valid_o, .ready_i, .status_o, .received_o,
    .msg_sender_o, .msg_protocol_o, .msg_payload_o, .msg_seq_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, plus one long hold-off to back up the block
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer_request(input logic rt, input logic [15:0] oid, input logic [3:0] obox,
                               input logic [15:0] did, input logic [3:0] dbox,
                               input logic dex, input logic [7:0] pr, input logic [63:0] pl);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    req_type_i <= rt;
    own_id_i <= oid;
    own_box_i <= obox;
    dest_id_i <= did;
    dest_box_i <= dbox;
    dest_exists_i <= dex;
    protocol_i <= pr;
    payload_i <= pl;
    do @(posedge clk_i); while (!ready_o);
  endtask

  task automatic send_mail(input logic [3:0] box, input logic [7:0] pr, input logic [63:0] pl);
    offer_request(OP_SEND[0], 16'($urandom), 4'($urandom), 16'($urandom_range(1, 65535)),
                  box, 1'b1, pr, pl);
  endtask

  task automatic fetch_mail(input logic [3:0] box);
    offer_request(OP_RECV[0], 16'($urandom), box, 16'($urandom), 4'($urandom), 1'($urandom),
                  8'($urandom), {$urandom, $urandom});
  endtask

  // drain, let the back end settle, then write all three codes
  task automatic load_codes(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    codes = '{a, b, c};
    for (int k = 0; k < 3; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= k[1:0];
      cfg_data_i <= codes[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) begin
      offer_request(1'($urandom), 16'($urandom), 4'($urandom), 16'($urandom), 4'($urandom),
                    1'($urandom), 8'($urandom), {$urandom, $urandom});
    end else if (roll < 60) begin
      send_mail(4'($urandom_range(0, 3)),
                ($urandom_range(9) == 0) ? 8'($urandom) : codes[$urandom_range(2)],
                {$urandom, $urandom});
    end else begin
      fetch_mail(4'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    load_codes(8'd0, 8'd1, 8'd2);
    // fill box 0 past capacity, then drain it past empty
    for (int k = 0; k < 9; k++) send_mail(4'd0, codes[k % 3], 64'hFFFF_FFFF_FFFF_FFFF - k);
    for (int k = 0; k < 9; k++) fetch_mail(4'd0);
    offer_request(OP_SEND[0], 16'hFFFF, 4'hF, 16'd0, 4'd1, 1'b1, 8'd0, 64'd1);
    offer_request(OP_SEND[0], 16'hFFFF, 4'hF, 16'hFFFF, 4'd1, 1'b0, 8'd0, 64'd1);
    offer_request(OP_SEND[0], 16'h0000, 4'h0, 16'hFFFF, 4'hF, 1'b1, 8'hFF, 64'd2);
    offer_request(OP_SEND[0], 16'hFFFF, 4'h0, 16'hFFFF, 4'hF, 1'b1, 8'd2, 64'd0);
    fetch_mail(4'hF);
    fetch_mail(4'hF);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        1: load_codes(8'hFF, 8'hFF, 8'h80);
        2: load_codes(8'h07, 8'h00, 8'hFF);
        default: ;
      endcase
      for (int m = 0; m < 4; m++) begin
        idle_pct = (m == 1 || m == 3) ? ((m == 3) ? 36 : 67) : 0;
        stall_pct = (m == 2 || m == 3) ? ((m == 3) ? 36 : 67) : 0;
        for (int n = 0; n < 78; n++) begin
          if (ph == 1 && m == 0 && n == 10) hold_req <= 1'b1;
          random_request();
        end
      end
    end
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) $display("tb_mailbox_slot_store_oldest_first passed");
    else $display("tb_mailbox_slot_store_oldest_first failed");
    $finish;
  end

  initial begin
    #24_000_000;
    $display("tb_mailbox_slot_store_oldest_first failed");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/msso_pkg.sv
hw/rtl/msso_front.sv
hw/rtl/msso_back.sv
hw/rtl/mailbox_slot_store_oldest_first.sv
test/msso_checker.sv
test/tb_mailbox_slot_store_oldest_first.sv
